FILE: hdl/lru_frame_replacer_assert.svh
// assertion helpers included by lru_frame_replacer.sv
`ifndef LRU_FRAME_REPLACER_ASSERT_SVH
`define LRU_FRAME_REPLACER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;
    localparam int FRAME_W     = 6;
    localparam int POOL_FRAMES = 64;
    localparam int NUM_FRAMES  = 1 << FRAME_W;
    localparam int COUNT_W     = 7;

    localparam logic [1:0] ACT_VICTIM = 2'd0;
    localparam logic [1:0] ACT_PIN    = 2'd1;
    localparam logic [1:0] ACT_UNPIN  = 2'd2;

    // link memory write request
    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] addr;
        logic [FRAME_W-1:0] data;
    } link_wr_t;
endpackage

FILE: hdl/lfr_ram.sv
`timescale 1ns / 1ps

module lfr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hdl/lru_frame_replacer.sv
`timescale 1ns / 1ps

// LRU frame replacer with pinning. Frames form a doubly linked list, newest
// at the head, with next and prev links held in two 64-entry synchronous
// RAMs indexed by frame number; present and evictable marks sit in flops.
// Unpin of a present frame, pin of the head and a victim miss go from idle to
// done; inserting an absent frame passes push; pinning a present one passes
// read, unlink and push. A victim walks from the tail toward the head, with a
// walk and a step per skipped frame (one link RAM read each), then unlinks
// it. One action is in flight at a time; a finished result sits in the output
// register while the next beat is accepted. No clearing pass after reset.
module lru_frame_replacer
    import lfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [FRAME_W-1:0] s_frame_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_victim_found,
    output logic [FRAME_W-1:0] m_victim_frame,
    output logic [COUNT_W-1:0] m_evictable_count
);
    `include "lru_frame_replacer_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_UNLINK, ST_PUSH, ST_WALK, ST_STEP, ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [FRAME_W-1:0]      cur_reg, cur_next;
    logic [FRAME_W-1:0]      head_reg, head_next;
    logic [FRAME_W-1:0]      tail_reg, tail_next;
    logic [COUNT_W-1:0]      used_reg, used_next;
    logic [COUNT_W-1:0]      evcnt_reg, evcnt_next;
    logic [NUM_FRAMES-1:0]   present_reg, present_next;
    logic [NUM_FRAMES-1:0]   evict_reg, evict_next;
    logic                    found_reg, found_next;
    logic [FRAME_W-1:0]      vframe_reg, vframe_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [FRAME_W-1:0]      m_frame_reg, m_frame_next;
    logic [COUNT_W-1:0]      m_count_reg, m_count_next;

    link_wr_t                next_wr, prev_wr;
    logic [FRAME_W-1:0]      next_rd, prev_rd;

    // link memories, both read at the current frame
    lfr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_wr.en),
        .wr_addr (next_wr.addr),
        .wr_data (next_wr.data),
        .rd_addr (cur_reg),
        .rd_data (next_rd)
    );

    lfr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_wr.en),
        .wr_addr (prev_wr.addr),
        .wr_data (prev_wr.data),
        .rd_addr (cur_reg),
        .rd_data (prev_rd)
    );

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_victim_found    = m_found_reg;
    assign m_victim_frame    = m_frame_reg;
    assign m_evictable_count = m_count_reg;

    // action sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cur_next     = cur_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        used_next    = used_reg;
        evcnt_next   = evcnt_reg;
        present_next = present_reg;
        evict_next   = evict_reg;
        found_next   = found_reg;
        vframe_next  = vframe_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_frame_next = m_frame_reg;
        m_count_next = m_count_reg;
        next_wr      = '0;
        prev_wr      = '0;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_action;
                    cur_next    = s_frame_number;
                    found_next  = 1'b0;
                    vframe_next = '0;
                    state_next  = ST_DONE;
                    if (s_action == ACT_VICTIM) begin
                        if (evcnt_reg != '0) begin
                            cur_next   = tail_reg;
                            state_next = ST_WALK;
                        end
                    end else if (s_action == ACT_PIN || s_action == ACT_UNPIN) begin
                        if (present_reg[s_frame_number]) begin
                            if (s_action == ACT_UNPIN) begin
                                if (!evict_reg[s_frame_number]) begin
                                    evict_next[s_frame_number] = 1'b1;
                                    evcnt_next = evcnt_reg + 1'b1;
                                end
                            end else begin
                                if (evict_reg[s_frame_number]) begin
                                    evict_next[s_frame_number] = 1'b0;
                                    evcnt_next = evcnt_reg - 1'b1;
                                end
                                if (s_frame_number != head_reg) begin
                                    state_next = ST_READ;
                                end
                            end
                        end else if (used_reg < COUNT_W'(POOL_FRAMES)) begin
                            state_next = ST_PUSH;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_UNLINK;
            end
            ST_WALK: begin
                // link read at cur issued this cycle either way
                state_next = evict_reg[cur_reg] ? ST_UNLINK : ST_STEP;
            end
            ST_STEP: begin
                cur_next   = prev_rd;
                state_next = ST_WALK;
            end
            ST_UNLINK: begin
                if (cur_reg == tail_reg) begin
                    tail_next = prev_rd;
                end else begin
                    prev_wr = '{en: 1'b1, addr: next_rd, data: prev_rd};
                end
                if (cur_reg == head_reg) begin
                    head_next = next_rd;
                end else begin
                    next_wr = '{en: 1'b1, addr: prev_rd, data: next_rd};
                end
                if (op_reg == ACT_VICTIM) begin
                    present_next[cur_reg] = 1'b0;
                    evict_next[cur_reg]   = 1'b0;
                    used_next   = used_reg - 1'b1;
                    evcnt_next  = evcnt_reg - 1'b1;
                    found_next  = 1'b1;
                    vframe_next = cur_reg;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                next_wr   = '{en: 1'b1, addr: cur_reg, data: head_reg};
                if (used_reg != '0) begin
                    prev_wr = '{en: 1'b1, addr: head_reg, data: cur_reg};
                end else begin
                    tail_next = cur_reg;
                end
                head_next = cur_reg;
                if (!present_reg[cur_reg]) begin
                    present_next[cur_reg] = 1'b1;
                    used_next = used_reg + 1'b1;
                    if (op_reg == ACT_UNPIN) begin
                        evict_next[cur_reg] = 1'b1;
                        evcnt_next = evcnt_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_frame_next = vframe_reg;
                    m_count_next = evcnt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            evcnt_reg   <= '0;
            present_reg <= '0;
            evict_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            evcnt_reg   <= evcnt_next;
            present_reg <= present_next;
            evict_reg   <= evict_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        cur_reg     <= cur_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        found_reg   <= found_next;
        vframe_reg  <= vframe_next;
        m_found_reg <= m_found_next;
        m_frame_reg <= m_frame_next;
        m_count_reg <= m_count_next;
    end

    // consistency of counters and marks, victim choice and the victim walk
    `LFR_ASSERT_IMP(a_evcnt_matches, 1'b1, $countones(evict_reg) == evcnt_reg, "evictable count off")
    `LFR_ASSERT_IMP(a_used_matches, 1'b1, $countones(present_reg) == used_reg, "used count off")
    `LFR_ASSERT_IMP(a_evict_present, 1'b1, (evict_reg & ~present_reg) == '0, "evictable but absent")
    `LFR_ASSERT_IMP(a_victim_evict,
        state_reg == ST_UNLINK && op_reg == ACT_VICTIM, evict_reg[cur_reg], "victim not evictable")
    `LFR_ASSERT_NXT(a_walk_live, state_reg == ST_WALK, present_reg[cur_reg] || state_reg != ST_STEP,
        "walk left the list")
endmodule
